>>> rtl/divisor_pair_enumerator_assert.svh
// Assertion macros for the divisor pair enumerator RTL.
`ifndef DIVISOR_PAIR_ENUMERATOR_ASSERT_SVH
`define DIVISOR_PAIR_ENUMERATOR_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DPE_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("divisor pair enumerator assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define DPE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("divisor pair enumerator assertion failed");

`endif

>>> rtl/dpe_pkg.sv
// Shared constants and controller/datapath interface types for the divisor pair enumerator.
`default_nettype none

package dpe_pkg;

	localparam int NUM_WIDTH_DEF = 16;
	localparam int IN_W = 16;
	localparam int SMALL_W = 8;
	localparam int COF_W = 16;
	localparam int KIND_W = 2;
	localparam int DIV_BITS = 8;

	localparam logic [KIND_W-1:0] KIND_PAIR = 2'd0;
	localparam logic [KIND_W-1:0] KIND_ROOT = 2'd1;
	localparam logic [KIND_W-1:0] KIND_NONE = 2'd2;

	typedef struct packed {
		logic load;
		logic div_start;
		logic div_step;
		logic advance;
		logic capture;
		logic [KIND_W-1:0] cap_kind;
		logic push;
		logic push_last;
	} dpe_cmd_t;

	typedef struct packed {
		logic n_zero;
		logic sq_lt;
		logic sq_eq;
		logic div_done;
		logic rem_zero;
		logic pend_valid;
		logic out_free;
	} dpe_sts_t;

endpackage

`default_nettype wire

>>> rtl/dpe_ctrl.sv
// Controller state machine that sequences candidates, divisions and result transactions.
`default_nettype none

module dpe_ctrl (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_stall,
	input  wire dpe_pkg::dpe_sts_t sts,
	output dpe_pkg::dpe_cmd_t     cmd
);

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_CHECK  = 3'd1;
	localparam logic [2:0] ST_DIV    = 3'd2;
	localparam logic [2:0] ST_FINISH = 3'd3;

	logic [2:0] state_q;
	logic [2:0] state_nxt;
	logic       slot_ok;

	assign in_stall = (state_q != ST_IDLE);
	assign slot_ok = !sts.pend_valid || sts.out_free;

	always_comb begin
		cmd = '0;
		cmd.cap_kind = dpe_pkg::KIND_PAIR;
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_nxt = ST_CHECK;
				end
			end
			ST_CHECK: begin
				if (sts.n_zero) begin
					cmd.capture = 1'b1;
					cmd.cap_kind = dpe_pkg::KIND_NONE;
					state_nxt = ST_FINISH;
				end else if (sts.sq_lt) begin
					cmd.div_start = 1'b1;
					state_nxt = ST_DIV;
				end else if (sts.sq_eq) begin
					if (slot_ok) begin
						cmd.push = sts.pend_valid;
						cmd.capture = 1'b1;
						cmd.cap_kind = dpe_pkg::KIND_ROOT;
						state_nxt = ST_FINISH;
					end
				end else begin
					state_nxt = ST_FINISH;
				end
			end
			ST_DIV: begin
				if (!sts.div_done) begin
					cmd.div_step = 1'b1;
				end else if (!sts.rem_zero) begin
					cmd.advance = 1'b1;
					state_nxt = ST_CHECK;
				end else if (slot_ok) begin
					cmd.push = sts.pend_valid;
					cmd.capture = 1'b1;
					cmd.cap_kind = dpe_pkg::KIND_PAIR;
					cmd.advance = 1'b1;
					state_nxt = ST_CHECK;
				end
			end
			ST_FINISH: begin
				if (sts.out_free) begin
					cmd.push = 1'b1;
					cmd.push_last = 1'b1;
					state_nxt = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

endmodule

`default_nettype wire

>>> rtl/dpe_datapath.sv
// Datapath with the candidate counter, the iterative divider, the held-back result and the output register.
`default_nettype none

module dpe_datapath #(
	parameter int NUM_WIDTH = dpe_pkg::NUM_WIDTH_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic [dpe_pkg::IN_W-1:0]    number,
	input  wire dpe_pkg::dpe_cmd_t           cmd,
	output dpe_pkg::dpe_sts_t                sts,
	output logic [dpe_pkg::SMALL_W-1:0]      small_divisor,
	output logic [dpe_pkg::COF_W-1:0]        cofactor,
	output logic [dpe_pkg::KIND_W-1:0]       kind,
	output logic                             last,
	output logic                             out_valid,
	input  wire logic                        out_stall
);

	localparam int SW = dpe_pkg::SMALL_W;
	localparam int CW = dpe_pkg::COF_W;
	localparam int KW = dpe_pkg::KIND_W;
	localparam int DIV_BITS = dpe_pkg::DIV_BITS;
	localparam int DW = (NUM_WIDTH + 1) / 2 + 1;
	localparam int SQ_W = 2 * DW;
	localparam int DIV_CYC = (NUM_WIDTH + DIV_BITS - 1) / DIV_BITS;
	localparam int QW = DIV_CYC * DIV_BITS;
	localparam int CNT_W = $clog2(DIV_CYC + 1);

	logic [NUM_WIDTH-1:0] n_q;
	logic [DW-1:0]        d_q;
	logic [SQ_W-1:0]      sq_q;
	logic [DW-1:0]        rem_q;
	logic [QW-1:0]        quo_q;
	logic [CNT_W-1:0]     div_cnt_q;

	logic [DW:0]          trial;
	logic [DW-1:0]        r_w;
	logic [QW-1:0]        q_w;

	logic                 pend_valid_q;
	logic [SW-1:0]        pend_small_q;
	logic [CW-1:0]        pend_cof_q;
	logic [KW-1:0]        pend_kind_q;

	logic                 out_valid_q;
	logic [SW-1:0]        out_small_q;
	logic [CW-1:0]        out_cof_q;
	logic [KW-1:0]        out_kind_q;
	logic                 out_last_q;

	logic [SQ_W-1:0]      n_ext;
	logic [CW-1:0]        cap_cof;
	logic [SW-1:0]        cap_small;

	assign n_ext = {{(SQ_W - NUM_WIDTH){1'b0}}, n_q};

	// Eight restoring division steps per cycle.
	always_comb begin
		r_w = rem_q;
		q_w = quo_q;
		trial = '0;
		for (int i = 0; i < DIV_BITS; i++) begin
			trial = {r_w, q_w[QW-1]};
			q_w = {q_w[QW-2:0], 1'b0};
			if (trial >= {1'b0, d_q}) begin
				r_w = DW'(trial - {1'b0, d_q});
				q_w[0] = 1'b1;
			end else begin
				r_w = trial[DW-1:0];
			end
		end
	end

	always_comb begin
		cap_small = SW'(d_q);
		cap_cof = '0;
		case (cmd.cap_kind)
			dpe_pkg::KIND_PAIR: cap_cof = CW'(quo_q[NUM_WIDTH-1:0]);
			dpe_pkg::KIND_NONE: cap_small = '0;
			default: cap_cof = '0;
		endcase
	end

	assign sts.n_zero = (n_q == '0);
	assign sts.sq_lt = (sq_q < n_ext);
	assign sts.sq_eq = (sq_q == n_ext);
	assign sts.div_done = (div_cnt_q == '0);
	assign sts.rem_zero = (rem_q == '0);
	assign sts.pend_valid = pend_valid_q;
	assign sts.out_free = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_cnt_q <= '0;
			pend_valid_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.div_start) begin
				div_cnt_q <= CNT_W'(DIV_CYC);
			end else if (cmd.div_step) begin
				div_cnt_q <= div_cnt_q - 1'b1;
			end
			if (cmd.load) begin
				pend_valid_q <= 1'b0;
			end else if (cmd.capture) begin
				pend_valid_q <= 1'b1;
			end else if (cmd.push) begin
				pend_valid_q <= 1'b0;
			end
			if (cmd.push) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			n_q <= number[NUM_WIDTH-1:0];
			d_q <= DW'(1);
			sq_q <= SQ_W'(1);
		end else if (cmd.advance) begin
			d_q <= d_q + 1'b1;
			sq_q <= sq_q + SQ_W'({d_q, 1'b1});
		end
		if (cmd.div_start) begin
			rem_q <= '0;
			quo_q <= QW'(n_q);
		end else if (cmd.div_step) begin
			rem_q <= r_w;
			quo_q <= q_w;
		end
		if (cmd.push) begin
			out_small_q <= pend_small_q;
			out_cof_q <= pend_cof_q;
			out_kind_q <= pend_kind_q;
			out_last_q <= cmd.push_last;
		end
		if (cmd.capture) begin
			pend_small_q <= cap_small;
			pend_cof_q <= cap_cof;
			pend_kind_q <= cmd.cap_kind;
		end
	end

	assign small_divisor = out_small_q;
	assign cofactor = out_cof_q;
	assign kind = out_kind_q;
	assign last = out_last_q;
	assign out_valid = out_valid_q;

endmodule

`default_nettype wire

>>> rtl/divisor_pair_enumerator.sv
// Top level of the divisor pair enumerator: controller, datapath and checks.
//
// One input transaction carries a number; its low NUM_WIDTH bits are used.
// The block lists the divisors by trial division over candidates d with
// d*d below the number. Each dividing candidate gives one output transaction
// with small_divisor d, cofactor number/d and kind pair. A perfect square
// ends with a kind root transaction carrying the root, and zero gives one
// kind none transaction. The final transaction of a number has last set.
// One number is worked at a time; in_stall stays high from acceptance until
// the final transaction is loaded into the output register.
// Each candidate passes through a bound check, two divider passes of eight
// quotient bits each for 16 bits, and a decision. A found divisor is held
// back one step so that the last flag is known when it is sent. While
// out_stall is high and the output is valid, the output holds and the
// controller waits before sending the next transaction. Reset clears the
// state machine and all valid flags; no clearing pass is needed.
`default_nettype none

module divisor_pair_enumerator #(
	parameter int NUM_WIDTH = dpe_pkg::NUM_WIDTH_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        in_valid,
	output logic                             in_stall,
	input  wire logic [dpe_pkg::IN_W-1:0]    number,
	output logic                             out_valid,
	input  wire logic                        out_stall,
	output logic [dpe_pkg::SMALL_W-1:0]      small_divisor,
	output logic [dpe_pkg::COF_W-1:0]        cofactor,
	output logic [dpe_pkg::KIND_W-1:0]       kind,
	output logic                             last
);

	dpe_pkg::dpe_cmd_t cmd;
	dpe_pkg::dpe_sts_t sts;

	dpe_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	dpe_datapath #(
		.NUM_WIDTH (NUM_WIDTH)
	) u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.number        (number),
		.cmd           (cmd),
		.sts           (sts),
		.small_divisor (small_divisor),
		.cofactor      (cofactor),
		.kind          (kind),
		.last          (last),
		.out_valid     (out_valid),
		.out_stall     (out_stall)
	);

`include "divisor_pair_enumerator_assert.svh"

	`DPE_ASSERT_SAME(a_idle_no_pending, clk, arst_n, !in_stall, !sts.pend_valid)
	`DPE_ASSERT_SAME(a_push_has_room, clk, arst_n, cmd.push, !out_valid || !out_stall)
	`DPE_ASSERT_NEXT(a_accept_then_busy, clk, arst_n, in_valid && !in_stall, in_stall)
	`DPE_ASSERT_SAME(a_none_is_last, clk, arst_n, out_valid && (kind == dpe_pkg::KIND_NONE), last)

endmodule

`default_nettype wire
